>>> design/wdwq_pkg.sv
`timescale 1ns / 1ps

package wdwq_pkg;

    localparam int CountWidth  = 8;
    localparam int GapWidth    = 16;
    localparam int PeriodWidth = 27;
    localparam int CfgIdxWidth = 3;
    localparam int CfgDatWidth = 27;
    localparam int InDataWidth  = 8;
    localparam int OutDataWidth = 32;

    typedef enum logic [CfgIdxWidth-1:0] {
        REG_MAX_SAMPLES       = 3'd0,
        REG_MIN_DRY_SAMPLES   = 3'd1,
        REG_USE_SWITCH_SOURCE = 3'd2,
        REG_SAMPLE_GAP_MS     = 3'd3,
        REG_PERIOD_WET_MS     = 3'd4,
        REG_PERIOD_DRY_MS     = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [PeriodWidth-1:0] next_delay_ms;
        logic                   window_done;
        logic                   report_wet;
        logic                   report_valid;
    } result_t;

endpackage

>>> design/wet_dry_window_qualifier.sv
`timescale 1ns / 1ps

// Each accepted input transaction's result is registered and offered as a result transaction in the cycle after.
// Throughput: one sample per cycle while results are taken; the output register frees as soon as the result is taken.
// The window counters and verdict state update in the same cycle that a sample is accepted.
// Reset (rst_n low, asynchronous) clears the window state, marks the first window and
// restores the register defaults (window length 1, dry minimum 1, all others zero).
module wet_dry_window_qualifier (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [wdwq_pkg::CfgIdxWidth-1:0]    cfg_index,
    input  logic [wdwq_pkg::CfgDatWidth-1:0]    cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0: sample_wet, then zero fill.
    input  logic [wdwq_pkg::InDataWidth-1:0]    s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Fields from bit 0: report_valid, report_wet, window_done, next_delay_ms[26:0], zero fill.
    output logic [wdwq_pkg::OutDataWidth-1:0]   m_axis_tdata
);
    import wdwq_pkg::*;

    logic [CountWidth-1:0]  max_samples_reg;
    logic [CountWidth-1:0]  min_dry_samples_reg;
    logic                   use_switch_source_reg;
    logic [GapWidth-1:0]    sample_gap_ms_reg;
    logic [PeriodWidth-1:0] period_wet_ms_reg;
    logic [PeriodWidth-1:0] period_dry_ms_reg;

    logic [CountWidth-1:0]  sample_count_reg, sample_count_next;
    logic [CountWidth-1:0]  dry_count_reg, dry_count_next;
    logic                   pending_wet_reg, pending_wet_next;
    logic                   held_wet_reg, held_wet_next;
    logic                   first_window_reg, first_window_next;

    logic                   out_valid_reg;
    result_t                result_reg, result_next;

    logic                   accept;
    logic                   sample_wet;
    logic [CountWidth-1:0]  win_len;
    logic [CountWidth-1:0]  dry_min;
    logic [CountWidth:0]    count_inc;
    logic [CountWidth:0]    dry_inc;
    logic                   pending_work;
    logic                   done;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign sample_wet    = s_axis_tdata[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_samples_reg       <= CountWidth'(1);
            min_dry_samples_reg   <= CountWidth'(1);
            use_switch_source_reg <= 1'b0;
            sample_gap_ms_reg     <= '0;
            period_wet_ms_reg     <= '0;
            period_dry_ms_reg     <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_MAX_SAMPLES:       max_samples_reg       <= cfg_data[CountWidth-1:0];
                REG_MIN_DRY_SAMPLES:   min_dry_samples_reg   <= cfg_data[CountWidth-1:0];
                REG_USE_SWITCH_SOURCE: use_switch_source_reg <= cfg_data[0];
                REG_SAMPLE_GAP_MS:     sample_gap_ms_reg     <= cfg_data[GapWidth-1:0];
                REG_PERIOD_WET_MS:     period_wet_ms_reg     <= cfg_data[PeriodWidth-1:0];
                REG_PERIOD_DRY_MS:     period_dry_ms_reg     <= cfg_data[PeriodWidth-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        win_len   = use_switch_source_reg ? max_samples_reg : CountWidth'(1);
        dry_min   = use_switch_source_reg ? min_dry_samples_reg : CountWidth'(1);
        count_inc = {1'b0, sample_count_reg} + 1'b1;
        dry_inc   = {1'b0, dry_count_reg} + 1'b1;

        pending_work      = pending_wet_reg;
        dry_count_next    = dry_count_reg;
        done              = 1'b0;
        held_wet_next     = held_wet_reg;
        first_window_next = first_window_reg;
        result_next       = '0;

        if (sample_wet)
        begin
            pending_work = 1'b1;
        end
        else
        begin
            if (dry_inc >= {1'b0, dry_min})
            begin
                done         = 1'b1;
                pending_work = 1'b0;
            end
            dry_count_next = dry_inc[CountWidth-1:0];
        end

        if (count_inc >= {1'b0, win_len})
        begin
            done = 1'b1;
        end

        if (done)
        begin
            sample_count_next = '0;
            dry_count_next    = '0;
            if ((pending_work != held_wet_reg) || first_window_reg)
            begin
                first_window_next        = 1'b0;
                held_wet_next            = pending_work;
                result_next.report_valid = 1'b1;
                result_next.report_wet   = pending_work;
            end
            pending_wet_next = 1'b0;
        end
        else
        begin
            sample_count_next = count_inc[CountWidth-1:0];
            pending_wet_next  = pending_work;
        end

        result_next.window_done = done;
        if (sample_count_next != '0)
        begin
            result_next.next_delay_ms = PeriodWidth'(sample_gap_ms_reg);
        end
        else if (first_window_next)
        begin
            result_next.next_delay_ms = '0;
        end
        else
        begin
            result_next.next_delay_ms = held_wet_next ? period_wet_ms_reg : period_dry_ms_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= '0;
            dry_count_reg    <= '0;
            pending_wet_reg  <= 1'b0;
            held_wet_reg     <= 1'b0;
            first_window_reg <= 1'b1;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                sample_count_reg <= sample_count_next;
                dry_count_reg    <= dry_count_next;
                pending_wet_reg  <= pending_wet_next;
                held_wet_reg     <= held_wet_next;
                first_window_reg <= first_window_next;
                out_valid_reg    <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OutDataWidth'(result_reg);

endmodule
